// ===== src/mt19937_generator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// MT19937 generator assertion macros
// Clocked property shorthands shared by the generator's checks.
// ----------------------------------------------------------------------------
`ifndef MT19937_GENERATOR_UNIT_ASSERT_SVH
`define MT19937_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_SAME(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("mt19937 generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("mt19937 generator check failed");

`endif

// ===== src/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator package
// Constants, types and the twist and tempering functions of the generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

	localparam int STATE_WORDS = 624;
	localparam int TAP_OFFSET  = 397;
	localparam int IDX_W       = $clog2(STATE_WORDS);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] SEED_MULT    = 32'd1812433253;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

	typedef enum logic [0:0] {
		OP_SEED = 1'b0,
		OP_DRAW = 1'b1
	} opcode_t;

	// Seeding unit to chain: shift request and the word to enter the tail.
	typedef struct packed {
		logic        busy;
		logic        shift;
		logic [31:0] word;
	} seed_out_t;

	// Next sequence word from the oldest word, its successor and the tap word.
	function automatic logic [31:0] twist_word(input logic [31:0] x0,
		input logic [31:0] x1, input logic [31:0] xm);
		logic [31:0] y;
		logic [31:0] v;
		y = {x0[31], x1[30:0]};
		v = xm ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TWIST_MATRIX;
		end
		return v;
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

// ===== src/mtg_cell.sv =====
// ----------------------------------------------------------------------------
// MT19937 state cell
// Holds one 32-bit state word and takes its neighbor's word on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_cell
	import mtg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        shift,
	input  wire logic [31:0] d,
	output logic      [31:0] q
);

	logic [31:0] word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

`default_nettype wire

// ===== src/mtg_seed.sv =====
// ----------------------------------------------------------------------------
// MT19937 seeding unit
// Produces the seed fill sequence, one word per cycle, into the chain tail.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_seed
	import mtg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] seed_value,
	input  wire logic [31:0] tail_word,
	output seed_out_t        seed_out
);

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      mixed;
	logic [31:0]      prod;

	// The tail cell holds the word written last cycle, so the recurrence
	// runs through a single multiplier with the chain as its register.
	assign mixed = tail_word ^ (tail_word >> 30);
	assign prod  = SEED_MULT * mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= IDX_W'(1);
		end else if (busy_q) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_comb begin
		seed_out.busy  = busy_q;
		seed_out.shift = start | busy_q;
		seed_out.word  = start ? seed_value : (prod + {{(32-IDX_W){1'b0}}, idx_q});
	end

endmodule

`default_nettype wire

// ===== src/mt19937_generator_unit.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator unit
// 32-bit Mersenne Twister with the state held in a shifting row of cells.
// ----------------------------------------------------------------------------
// A draw request is taken every cycle unless in_stall is high (seed fill or
// stalled output word); its tempered word appears in the output register on
// the next cycle. The state lives in a row of 624 word cells that shifts once
// per draw, and the twist reads fixed cells (the oldest, its neighbor and the
// tap 397 places on), so no regeneration pause ever occurs. A seed request
// returns nothing and holds off further requests until the row is refilled,
// since the fill runs through one multiplier and enters one word per cycle
// at the row's tail. A draw before the first seed returns an undefined word.
`default_nettype none

`include "mt19937_generator_unit_assert.svh"

module mt19937_generator_unit
	import mtg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [0:0]  opcode,
	input  wire logic [31:0] seed_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] random_word
);

	logic        in_acc;
	logic        draw_acc;
	logic        seed_acc;
	logic        chain_shift;
	logic [31:0] new_word;
	logic [31:0] tail_in;
	logic [31:0] cell_word [STATE_WORDS];
	seed_out_t   seed_out;
	logic        out_valid_q;
	logic [31:0] out_word_q;

	assign in_stall = seed_out.busy | (out_valid_q & out_stall);
	assign in_acc   = in_valid & ~in_stall;
	assign draw_acc = in_acc & (opcode == OP_DRAW);
	assign seed_acc = in_acc & (opcode == OP_SEED);

	mtg_seed u_seed (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (seed_acc),
		.seed_value (seed_value),
		.tail_word  (cell_word[STATE_WORDS-1]),
		.seed_out   (seed_out)
	);

	assign new_word    = twist_word(cell_word[0], cell_word[1], cell_word[TAP_OFFSET]);
	assign chain_shift = seed_out.shift | draw_acc;
	assign tail_in     = seed_out.shift ? seed_out.word : new_word;

	for (genvar g = 0; g < STATE_WORDS; g++) begin : g_cell
		if (g == STATE_WORDS - 1) begin : g_tail
			mtg_cell u_cell (
				.clk   (clk),
				.shift (chain_shift),
				.d     (tail_in),
				.q     (cell_word[g])
			);
		end else begin : g_body
			mtg_cell u_cell (
				.clk   (clk),
				.shift (chain_shift),
				.d     (cell_word[g+1]),
				.q     (cell_word[g])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_stall == 1'b0) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_acc) begin
			out_word_q <= temper(new_word);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	`MTG_ASSERT_NEXT(a_seed_holds_off, clk, arst_n, seed_acc, in_stall)
	`MTG_ASSERT_NEXT(a_draw_gives_word, clk, arst_n, draw_acc, out_valid)
	`MTG_ASSERT_SAME(a_fill_shifts, clk, arst_n, seed_out.busy, chain_shift && !draw_acc)
	`MTG_ASSERT_SAME(a_word_from_draw, clk, arst_n, $rose(out_valid), $past(draw_acc))

endmodule

`default_nettype wire

// ===== dv/mt19937_generator_checker.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator checker
// Watches both channels of the generator, keeps its own copy of the twister
// state, predicts the word for every accepted draw request and compares each
// accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module mt19937_generator_checker
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [0:0]  opcode,
	input  logic [31:0] seed_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] random_word,
	output int          fail_count,
	output int          words_pending
);

	logic [31:0] mt_words [STATE_WORDS];
	int          mt_pos;
	logic [31:0] predicted_words [$];

	initial begin
		fail_count    = 0;
		words_pending = 0;
		mt_pos        = STATE_WORDS;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin : predict_and_compare
		logic [31:0] prev;
		logic [31:0] y;
		logic [31:0] v;
		logic [31:0] w;
		int          i;

		if (arst_n) begin
			// Take the request first so that a word leaving on the same edge
			// still finds its prediction.
			if (in_valid && !in_stall) begin
				if (opcode == OP_SEED) begin
					mt_words[0] = seed_value;
					for (i = 1; i < STATE_WORDS; i++) begin
						prev        = mt_words[i-1];
						mt_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
					end
					mt_pos = STATE_WORDS;
				end else begin
					if (mt_pos >= STATE_WORDS) begin
						for (i = 0; i < STATE_WORDS; i++) begin
							y = {mt_words[i][31], mt_words[(i + 1) % STATE_WORDS][30:0]};
							v = mt_words[(i + TAP_OFFSET) % STATE_WORDS] ^ (y >> 1);
							if (y[0]) begin
								v = v ^ TWIST_MATRIX;
							end
							mt_words[i] = v;
						end
						mt_pos = 0;
					end
					w = mt_words[mt_pos];
					mt_pos++;
					w = w ^ (w >> 11);
					w = w ^ ((w << 7) & TEMPER_B);
					w = w ^ ((w << 15) & TEMPER_C);
					w = w ^ (w >> 18);
					predicted_words.push_back(w);
				end
			end

			if (out_valid && !out_stall) begin
				if (predicted_words.size() == 0) begin
					report_mismatch($sformatf("word %08h with no draw request pending",
						random_word));
				end else begin
					w = predicted_words.pop_front();
					if (random_word !== w) begin
						report_mismatch($sformatf("random_word %08h, predicted %08h",
							random_word, w));
					end
				end
			end

			words_pending <= predicted_words.size();
		end
	end

endmodule

// ===== dv/mt19937_generator_unit_test.sv =====
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives seed and draw requests: a directed opening, then four idle and
// stall phases, one long draw run past the regeneration point and then
// random mixes of draws and occasional reseeds. The checker predicts and
// compares; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module mt19937_generator_unit_test;
	import mtg_pkg::*;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [0:0]  opcode     = OP_SEED;
	logic [31:0] seed_value = 32'h0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [31:0] random_word;

	int fail_count;
	int words_pending;
	int send_gap_pct = 0;
	int stall_pct    = 0;

	int gap_pct_by_phase [4]   = '{0, 52, 0, 20};
	int stall_pct_by_phase [4] = '{0, 0, 52, 20};

	mt19937_generator_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

	mt19937_generator_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.seed_value    (seed_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.random_word   (random_word),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Presents one request, with random idle cycles ahead of it, and returns
	// right after the edge at which it was accepted.
	task automatic send_request(input opcode_t op, input logic [31:0] sv);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid   <= 1'b0;
			opcode     <= opcode_t'($urandom_range(1));
			seed_value <= $urandom;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		seed_value <= sv;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		int ph;
		int n;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: seed extremes, back-to-back seeds, draws whose
		// ignored seed field holds all zeros and all ones.
		send_request(OP_SEED, 32'h0000_0000);
		send_request(OP_DRAW, 32'h0000_0000);
		send_request(OP_DRAW, 32'hffff_ffff);
		send_request(OP_DRAW, $urandom);
		send_request(OP_SEED, 32'hffff_ffff);
		send_request(OP_DRAW, 32'hffff_ffff);
		send_request(OP_DRAW, 32'h0000_0000);
		send_request(OP_SEED, 32'd5489);
		send_request(OP_DRAW, $urandom);
		send_request(OP_DRAW, $urandom);
		send_request(OP_DRAW, $urandom);
		send_request(OP_SEED, 32'h1234_5678);
		send_request(OP_SEED, 32'h8000_0000);
		send_request(OP_DRAW, $urandom);
		send_request(OP_DRAW, $urandom);
		send_request(OP_SEED, 32'h0000_0001);
		send_request(OP_DRAW, $urandom);

		for (ph = 0; ph < 4; ph++) begin
			send_gap_pct = gap_pct_by_phase[ph];
			stall_pct    = stall_pct_by_phase[ph];
			if (ph == 0) begin
				// One long run after a seed carries the position past the
				// end of the table, so a regeneration falls inside it.
				send_request(OP_SEED, $urandom);
				for (n = 0; n < 660; n++) begin
					send_request(OP_DRAW, $urandom);
				end
			end else begin
				for (n = 0; n < 360; n++) begin
					if ($urandom_range(119) == 0) begin
						send_request(OP_SEED, $urandom);
					end else begin
						send_request(OP_DRAW, $urandom);
					end
				end
			end
		end

		in_valid     <= 1'b0;
		send_gap_pct = 0;
		stall_pct    = 0;
		@(posedge clk);
		while (words_pending != 0) begin
			@(posedge clk);
		end
		// A seed fill keeps the block busy until the whole table is refilled.
		repeat (700) @(posedge clk);

		if (fail_count == 0 && words_pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#(20 * 800_000);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/mtg_pkg.sv
src/mtg_cell.sv
src/mtg_seed.sv
src/mt19937_generator_unit.sv
dv/mt19937_generator_checker.sv
dv/mt19937_generator_unit_test.sv
